/* rtl/core/fsd_pkg.sv */
// Shared types and code constants for the flux stream decoder.
package fsd_pkg;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhTwo     = 3'd1,
    PhV16Hi   = 3'd2,
    PhV16Lo   = 3'd3,
    PhSkip    = 3'd4,
    PhOobType = 3'd5,
    PhOobLo   = 3'd6,
    PhOobHi   = 3'd7
  } phase_e;

  localparam logic [7:0] CodeTwoMax = 8'h07;
  localparam logic [7:0] CodeNop    = 8'h08;
  localparam logic [7:0] CodeSkip1  = 8'h09;
  localparam logic [7:0] CodeSkip2  = 8'h0A;
  localparam logic [7:0] CodeOvf    = 8'h0B;
  localparam logic [7:0] CodeV16    = 8'h0C;
  localparam logic [7:0] CodeOob    = 8'h0D;
  localparam logic [7:0] OobTypeEof = 8'h0D;

  localparam logic [31:0] OvfStep = 32'h0001_0000;
  localparam int unsigned LimitWidth = 24;
  localparam int unsigned TotalWidth = 24;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  held;
    logic [15:0] skip_left;
    logic [31:0] ovf;
    logic        oob_eof;
    logic        halted;
  } state_t;

  localparam state_t StateReset = '{
    phase:     PhIdle,
    held:      8'h00,
    skip_left: 16'h0000,
    ovf:       32'h0000_0000,
    oob_eof:   1'b0,
    halted:    1'b0
  };

  typedef struct packed {
    logic                  has_flux;
    logic [31:0]           flux_ticks;
    logic                  stream_done;
    logic [TotalWidth-1:0] flux_total;
  } result_t;

endpackage

/* rtl/core/fsd_decode.sv */
// Next-state and result logic for one stream byte.
module fsd_decode #(
  parameter int unsigned CountWidth = 24
) (
  input  fsd_pkg::state_t                  state_i,
  input  logic [CountWidth-1:0]            count_i,
  input  logic [7:0]                       byte_i,
  input  logic                             last_i,
  input  logic [fsd_pkg::LimitWidth-1:0]   max_count_i,
  output fsd_pkg::state_t                  state_o,
  output logic [CountWidth-1:0]            count_o,
  output logic                             emit_o,
  output fsd_pkg::result_t                 result_o
);
  import fsd_pkg::*;

  function automatic logic lim_f(input logic [CountWidth-1:0] c,
                                 input logic [LimitWidth-1:0] m);
    return (32'(c) >= 32'(m)) || (c == '1);
  endfunction

  state_t                st;
  logic [CountWidth-1:0] cnt;
  logic                  has;
  logic [15:0]           v16;
  logic [31:0]           ticks;
  logic [31:0]           cnt32;
  logic [15:0]           blk_len;

  always_comb begin
    st       = state_i;
    cnt      = count_i;
    has      = 1'b0;
    v16      = 16'h0000;
    ticks    = 32'h0000_0000;
    blk_len  = {byte_i, state_i.held};

    if (!st.halted && lim_f(cnt, max_count_i)) begin
      st.halted = 1'b1;
    end

    if (!st.halted) begin
      case (st.phase)
        PhIdle: begin
          if (byte_i <= CodeTwoMax) begin
            st.held  = byte_i;
            st.phase = PhTwo;
          end else if (byte_i == CodeNop) begin
            st.phase = PhIdle;
          end else if (byte_i == CodeSkip1) begin
            st.skip_left = 16'd1;
            st.phase     = PhSkip;
          end else if (byte_i == CodeSkip2) begin
            st.skip_left = 16'd2;
            st.phase     = PhSkip;
          end else if (byte_i == CodeOvf) begin
            st.ovf = st.ovf + OvfStep;
          end else if (byte_i == CodeV16) begin
            st.phase = PhV16Hi;
          end else if (byte_i == CodeOob) begin
            st.phase = PhOobType;
          end else begin
            has = 1'b1;
            v16 = {8'h00, byte_i};
          end
        end
        PhTwo, PhV16Lo: begin
          has      = 1'b1;
          v16      = {st.held, byte_i};
          st.phase = PhIdle;
        end
        PhV16Hi: begin
          st.held  = byte_i;
          st.phase = PhV16Lo;
        end
        PhSkip: begin
          if (st.skip_left <= 16'd1) begin
            st.skip_left = 16'd0;
            st.phase     = PhIdle;
          end else begin
            st.skip_left = st.skip_left - 16'd1;
          end
        end
        PhOobType: begin
          st.oob_eof = (byte_i == OobTypeEof);
          st.phase   = PhOobLo;
        end
        PhOobLo: begin
          st.held  = byte_i;
          st.phase = PhOobHi;
        end
        PhOobHi: begin
          if (st.oob_eof) begin
            st.halted = 1'b1;
            st.phase  = PhIdle;
          end else if (blk_len == 16'd0) begin
            st.phase = PhIdle;
          end else begin
            st.skip_left = blk_len;
            st.phase     = PhSkip;
          end
        end
        default: begin
          st.phase = PhIdle;
        end
      endcase
    end

    if (has) begin
      ticks  = {16'h0000, v16} + st.ovf;
      st.ovf = 32'h0000_0000;
      cnt    = cnt + CountWidth'(1);
      if (lim_f(cnt, max_count_i)) begin
        st.halted = 1'b1;
      end
    end

    cnt32 = 32'(cnt);

    result_o.has_flux    = has;
    result_o.flux_ticks  = ticks;
    result_o.stream_done = last_i;
    result_o.flux_total  = cnt32[TotalWidth-1:0];
    emit_o               = has || last_i;

    if (last_i) begin
      st  = StateReset;
      cnt = '0;
    end

    state_o = st;
    count_o = cnt;
  end

endmodule

/* rtl/core/flux_stream_decoder_top.sv */
// Flux stream decoder: parses capture bytes into flux interval tick counts.
// A result is registered into the output register, or into the skid register while the output stalls.
// Throughput: one byte per cycle while the skid buffer is empty; parser state updates in the accept cycle.
// A two-entry result buffer lets input continue during an output stall until the skid entry is filled.
// Reset clears the parser, the count and the buffer; the limit resets to max.
module flux_stream_decoder_top #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fsd_pkg::LimitWidth-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          stream_byte_i,
  input  logic                                last_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                has_flux_o,
  output logic [31:0]                         flux_ticks_o,
  output logic                                stream_done_o,
  output logic [fsd_pkg::TotalWidth-1:0]      flux_total_o
);
  import fsd_pkg::*;

  logic [LimitWidth-1:0]  max_q;
  state_t                 st_q, st_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic                   dec_emit;
  result_t                dec_res;

  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    accept, emit, out_free;

  fsd_decode #(
    .CountWidth(COUNT_WIDTH)
  ) u_decode (
    .state_i    (st_q),
    .count_i    (cnt_q),
    .byte_i     (stream_byte_i),
    .last_i     (last_byte_i),
    .max_count_i(max_q),
    .state_o    (st_d),
    .count_o    (cnt_d),
    .emit_o     (dec_emit),
    .result_o   (dec_res)
  );

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = accept && dec_emit;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '1;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StateReset;
      cnt_q <= '0;
    end else if (accept) begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= emit;
      end
    end else if (emit) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (emit) begin
        out_q <= dec_res;
      end
    end else if (emit) begin
      skid_q <= dec_res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign has_flux_o    = out_q.has_flux;
  assign flux_ticks_o  = out_q.flux_ticks;
  assign stream_done_o = out_q.stream_done;
  assign flux_total_o  = out_q.flux_total;

endmodule

/* rtl/core/fsd_checker.sv */
// Port-level checks for the flux stream decoder, bound to the top level.
module fsd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic                           has_flux_o,
  input logic [31:0]                    flux_ticks_o,
  input logic                           stream_done_o,
  input logic [fsd_pkg::TotalWidth-1:0] flux_total_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(flux_ticks_o)
      && $stable(flux_total_o) && $stable(stream_done_o))
    else $error("result changed while stalled");

  a_no_flux_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_flux_o |-> flux_ticks_o == 32'h0000_0000)
    else $error("ticks nonzero without flux");

  a_result_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stream_done_o |-> has_flux_o)
    else $error("result with neither flux nor done");

  a_total_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_flux_o |-> flux_total_o != '0)
    else $error("flux emitted with zero total");

endmodule

bind flux_stream_decoder_top fsd_checker u_fsd_checker (.*);
